@@ sv/twpa_pkg.sv @@
`timescale 1ns / 1ps

package twpa_pkg;

  localparam int DATA_W    = 32;
  localparam int SUM_W     = 37;
  localparam int NUM_WIN   = 3;
  localparam int NUM_AXES  = 3;
  localparam int NUM_LANES = NUM_WIN * NUM_AXES;
  localparam int LANE_W    = $clog2(NUM_LANES);
  localparam int BIT_W     = $clog2(SUM_W);
  localparam int RD_STEPS  = NUM_WIN + 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] short_avg_x;
    logic signed [DATA_W-1:0] short_avg_y;
    logic signed [DATA_W-1:0] short_avg_z;
    logic signed [DATA_W-1:0] mid_avg_x;
    logic signed [DATA_W-1:0] mid_avg_y;
    logic signed [DATA_W-1:0] mid_avg_z;
    logic signed [DATA_W-1:0] long_avg_x;
    logic signed [DATA_W-1:0] long_avg_y;
    logic signed [DATA_W-1:0] long_avg_z;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic step;
    logic first;
  } div_ctl_t;

endpackage

@@ sv/triple_window_position_average.sv @@
`timescale 1ns / 1ps

// Moving average of 3-D position samples (signed Q16.16) over three window
// lengths. Each accepted transaction returns one result holding the per-axis
// mean of the last min(n, W) samples for the short, middle and long windows,
// truncated toward zero, where n counts samples since reset. One transaction
// runs three history reads, a bit-serial update of all nine running sums,
// nine bit-serial divisions through one shared divider (which dominates), and
// a bit-serial sign fix of the quotients. A new transaction is accepted once
// the previous one has been handed to the output register, which holds it
// until taken.

module triple_window_position_average_unit #(
  parameter int SHORT_WINDOW  = 10,
  parameter int MID_WINDOW    = 20,
  parameter int LONG_WINDOW   = 30,
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  twpa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output twpa_pkg::out_item_t  out_data
);

  localparam int DATA_W = twpa_pkg::DATA_W;
  localparam int SUM_W  = twpa_pkg::SUM_W;
  localparam int NLANE  = twpa_pkg::NUM_LANES;
  localparam int NWIN   = twpa_pkg::NUM_WIN;
  localparam int NAXES  = twpa_pkg::NUM_AXES;
  localparam int BIT_W  = twpa_pkg::BIT_W;
  localparam int LANE_W = twpa_pkg::LANE_W;

  localparam int WIN_S = (SHORT_WINDOW < 1) ? 1 :
                         (SHORT_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : SHORT_WINDOW;
  localparam int WIN_M = (MID_WINDOW < 1) ? 1 :
                         (MID_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : MID_WINDOW;
  localparam int WIN_L = (LONG_WINDOW < 1) ? 1 :
                         (LONG_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : LONG_WINDOW;
  localparam int CAP_SM = (WIN_S > WIN_M) ? WIN_S : WIN_M;
  localparam int CAP    = (CAP_SM > WIN_L) ? CAP_SM : WIN_L;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);

  twpa_pkg::state_t state_r, state_nxt;

  logic [BIT_W-1:0]      bit_r;
  logic [1:0]            div_win_r;
  logic [1:0]            div_axis_r;
  logic [CNT_W-1:0]      count_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  neg_r;

  logic [DATA_W-1:0]     nv_r   [NAXES];
  logic [DATA_W-1:0]     old_r  [NLANE];
  logic [SUM_W-1:0]      sum_r  [NLANE];
  logic [1:0]            cy_r   [NLANE];
  logic [DATA_W-1:0]     quot_r [NLANE];
  logic                  inc_r  [NLANE];

  logic [3*DATA_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [3*DATA_W-1:0]   rd_data_r;

  logic                  out_valid_r;
  twpa_pkg::out_item_t   out_data_r;

  logic [CNT_W-1:0]      win_len  [NWIN];
  logic [SLOT_W:0]       win_slot [NWIN];
  logic                  full     [NWIN];
  logic [2:0]            upd_sum  [NLANE];

  logic [SLOT_W:0]       slot_ext;
  logic [SLOT_W:0]       rd_w;
  logic [SLOT_W-1:0]     rd_addr;
  logic [1:0]            rd_win;

  logic [LANE_W-1:0]     div_lane;
  logic [CNT_W-1:0]      div_n;
  logic                  msb;
  logic                  neg_cur;
  logic                  d_bit;
  logic                  q_bit;
  logic                  exact;
  twpa_pkg::div_ctl_t    div_ctl;

  logic                  sum_last;
  logic                  fix_last;
  logic                  rd_last;
  logic                  div_end;
  logic                  out_load;

  assign win_len[0]  = CNT_W'(WIN_S);
  assign win_len[1]  = CNT_W'(WIN_M);
  assign win_len[2]  = CNT_W'(WIN_L);
  assign win_slot[0] = (SLOT_W+1)'(WIN_S);
  assign win_slot[1] = (SLOT_W+1)'(WIN_M);
  assign win_slot[2] = (SLOT_W+1)'(WIN_L);

  assign sum_last = (bit_r == BIT_W'(SUM_W - 1));
  assign fix_last = (bit_r == BIT_W'(DATA_W - 1));
  assign rd_last  = (bit_r == BIT_W'(twpa_pkg::RD_STEPS - 1));
  assign div_end  = sum_last && (div_win_r == 2'(NWIN - 1)) && (div_axis_r == 2'(NAXES - 1));
  assign out_load = (state_r == twpa_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // oldest slot of the window being read
  always_comb begin
    rd_win   = (bit_r < BIT_W'(NWIN)) ? bit_r[1:0] : 2'd0;
    slot_ext = {1'b0, slot_r};
    rd_w     = win_slot[rd_win];
    if (slot_ext >= rd_w) begin
      rd_addr = SLOT_W'(slot_ext - rd_w);
    end else begin
      rd_addr = SLOT_W'(slot_ext + (SLOT_W+1)'(HISTORY_DEPTH) - rd_w);
    end
  end

  // serial sum + new - old, all nine lanes side by side
  always_comb begin
    for (int k = 0; k < NWIN; k++) begin
      full[k] = (count_r >= win_len[k]);
      for (int a = 0; a < NAXES; a++) begin
        upd_sum[k*NAXES + a] = 3'(sum_r[k*NAXES + a][0]) + 3'(nv_r[a][0])
                             + 3'(full[k] & ~old_r[k*NAXES + a][0])
                             + {1'b0, cy_r[k*NAXES + a]};
      end
    end
  end

  // divider feed: magnitude trick, negative sums enter as their complement
  always_comb begin
    div_lane = LANE_W'({div_win_r, 1'b0}) + LANE_W'(div_win_r) + LANE_W'(div_axis_r);
    div_n    = (count_r < win_len[div_win_r]) ? count_r : win_len[div_win_r];
    msb      = sum_r[div_lane][SUM_W-1];
    neg_cur  = (bit_r == '0) ? msb : neg_r;
    d_bit    = msb ^ neg_cur;
    div_ctl.step  = (state_r == twpa_pkg::ST_DIV);
    div_ctl.first = (bit_r == '0);
  end

  twpa_serial_div #(
    .DIV_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .ctl     (div_ctl),
    .d_bit   (d_bit),
    .divisor (div_n),
    .q_bit   (q_bit),
    .exact   (exact)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      twpa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = twpa_pkg::ST_READ;
        end
      end
      twpa_pkg::ST_READ: begin
        if (rd_last) begin
          state_nxt = twpa_pkg::ST_UPDATE;
        end
      end
      twpa_pkg::ST_UPDATE: begin
        if (sum_last) begin
          state_nxt = twpa_pkg::ST_DIV;
        end
      end
      twpa_pkg::ST_DIV: begin
        if (div_end) begin
          state_nxt = twpa_pkg::ST_FIX;
        end
      end
      twpa_pkg::ST_FIX: begin
        if (fix_last) begin
          state_nxt = twpa_pkg::ST_DONE;
        end
      end
      twpa_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = twpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = twpa_pkg::ST_IDLE;
      end
    endcase
  end

  // control counters and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r      <= '0;
      div_win_r  <= '0;
      div_axis_r <= '0;
      count_r    <= '0;
      slot_r     <= '0;
      for (int l = 0; l < NLANE; l++) begin
        sum_r[l] <= '0;
      end
    end else begin
      if ((state_r != state_nxt) || (state_r == twpa_pkg::ST_DIV && sum_last)) begin
        bit_r <= '0;
      end else if (state_r != twpa_pkg::ST_IDLE && state_r != twpa_pkg::ST_DONE) begin
        bit_r <= bit_r + BIT_W'(1);
      end

      if (state_r == twpa_pkg::ST_UPDATE) begin
        div_win_r  <= '0;
        div_axis_r <= '0;
        for (int l = 0; l < NLANE; l++) begin
          sum_r[l] <= {upd_sum[l][0], sum_r[l][SUM_W-1:1]};
        end
        if (sum_last) begin
          if (count_r < CNT_W'(CAP)) begin
            count_r <= count_r + CNT_W'(1);
          end
          slot_r <= (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
      end

      if (state_r == twpa_pkg::ST_DIV) begin
        sum_r[div_lane] <= {sum_r[div_lane][SUM_W-2:0], msb};
        if (sum_last) begin
          if (div_axis_r == 2'(NAXES - 1)) begin
            div_axis_r <= '0;
            div_win_r  <= div_win_r + 2'd1;
          end else begin
            div_axis_r <= div_axis_r + 2'd1;
          end
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (state_r == twpa_pkg::ST_IDLE && in_valid) begin
      nv_r[0] <= in_data.pos_x;
      nv_r[1] <= in_data.pos_y;
      nv_r[2] <= in_data.pos_z;
    end

    if (state_r == twpa_pkg::ST_READ) begin
      for (int k = 0; k < NWIN; k++) begin
        for (int a = 0; a < NAXES; a++) begin
          if (bit_r == BIT_W'(k + 1)) begin
            old_r[k*NAXES + a] <= rd_data_r[a*DATA_W +: DATA_W];
          end
          if (rd_last) begin
            cy_r[k*NAXES + a] <= {1'b0, full[k]};
          end
        end
      end
    end

    if (state_r == twpa_pkg::ST_UPDATE) begin
      for (int a = 0; a < NAXES; a++) begin
        nv_r[a] <= {nv_r[a][DATA_W-1], nv_r[a][DATA_W-1:1]};
      end
      for (int l = 0; l < NLANE; l++) begin
        old_r[l] <= {old_r[l][DATA_W-1], old_r[l][DATA_W-1:1]};
        cy_r[l]  <= upd_sum[l][2:1];
      end
    end

    if (state_r == twpa_pkg::ST_DIV) begin
      neg_r            <= neg_cur;
      quot_r[div_lane] <= {quot_r[div_lane][DATA_W-2:0], q_bit ^ neg_cur};
      if (sum_last) begin
        inc_r[div_lane] <= neg_cur & ~exact;
      end
    end

    // serial increment finishes the negation of negative quotients
    if (state_r == twpa_pkg::ST_FIX) begin
      for (int l = 0; l < NLANE; l++) begin
        quot_r[l] <= {quot_r[l][0] ^ inc_r[l], quot_r[l][DATA_W-1:1]};
        inc_r[l]  <= quot_r[l][0] & inc_r[l];
      end
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (state_r == twpa_pkg::ST_READ) begin
      rd_data_r <= hist_mem[rd_addr];
    end
    if (state_r == twpa_pkg::ST_UPDATE && bit_r == '0) begin
      hist_mem[slot_r] <= {nv_r[2], nv_r[1], nv_r[0]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.short_avg_x <= quot_r[0];
      out_data_r.short_avg_y <= quot_r[1];
      out_data_r.short_avg_z <= quot_r[2];
      out_data_r.mid_avg_x   <= quot_r[3];
      out_data_r.mid_avg_y   <= quot_r[4];
      out_data_r.mid_avg_z   <= quot_r[5];
      out_data_r.long_avg_x  <= quot_r[6];
      out_data_r.long_avg_y  <= quot_r[7];
      out_data_r.long_avg_z  <= quot_r[8];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == twpa_pkg::ST_READ))
    else $error("accepted transaction did not start history read");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(CAP)))
    else $error("sample count above largest window");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == twpa_pkg::ST_DONE))
    else $error("result appeared without finished computation");

  a_div_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twpa_pkg::ST_DIV) |-> (div_lane < LANE_W'(NLANE)))
    else $error("divider lane out of range");

endmodule

@@ sv/twpa_serial_div.sv @@
`timescale 1ns / 1ps

module twpa_serial_div #(
  parameter int DIV_W = 6
) (
  input  logic                clk,
  input  twpa_pkg::div_ctl_t  ctl,
  input  logic                d_bit,
  input  logic [DIV_W-1:0]    divisor,
  output logic                q_bit,
  output logic                exact
);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_cur;
  logic [DIV_W-1:0] rem_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  // restoring step, one quotient bit per cycle while ctl.step is set
  always_comb begin
    rem_cur = ctl.first ? '0 : rem_r;
    trial   = {rem_cur, d_bit};
    diff    = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      q_bit   = 1'b1;
      rem_nxt = diff[DIV_W-1:0];
    end else begin
      q_bit   = 1'b0;
      rem_nxt = trial[DIV_W-1:0];
    end
    exact = (rem_nxt == (divisor - DIV_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      rem_r <= rem_nxt;
    end
  end

endmodule
